// ===== rtl/core/wbkgl_pkg.sv =====
// Package with the shared types, widths and defaults of the burst and gap limiter.
package wbkgl_pkg;

   localparam int TIME_BITS  = 48;
   localparam int CHAN_BITS  = 6;
   localparam int CFG_BITS   = 32;
   localparam int BURST_BITS = 6;
   localparam int CSR_IDX_BITS = 2;

   localparam int RING_DEPTH_DEFAULT    = 32;
   localparam int CHANNEL_COUNT_DEFAULT = 64;

   localparam logic [CFG_BITS-1:0]   WINDOW_RESET = 32'd30000;
   localparam logic [BURST_BITS-1:0] BURST_RESET  = 6'd20;
   localparam logic [CFG_BITS-1:0]   GAP_RESET    = 32'd1000;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BURST  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAP    = 2'd2;

   typedef struct packed {
      logic [TIME_BITS-1:0] now_time;
      logic [CHAN_BITS-1:0] channel_index;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] grant_time;
      logic                 was_delayed;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic pop;
      logic compute;
      logic merge;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic prune_hit;
      logic out_busy;
   } status_type;

endpackage

// ===== rtl/core/windowed_burst_and_key_gap_limiter_unit.sv =====
// Top level of the windowed burst and per-channel gap send limiter.
// A result is registered when its transaction commits, after the prune, compute and merge
// steps; pruning drops expired stamps from the ring, one per cycle at the ring read port.
// A new transaction is taken only in the idle state, once the last one has committed.
// Reset: synchronous and active high; afterwards the channel table is cleared one entry per
// cycle, every entry in turn, with req_ready low, while configuration writes are taken.
module windowed_burst_and_key_gap_limiter_unit #(
   parameter int RING_DEPTH    = wbkgl_pkg::RING_DEPTH_DEFAULT,
   parameter int CHANNEL_COUNT = wbkgl_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  wbkgl_pkg::req_type                 req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output wbkgl_pkg::rsp_type                 rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wbkgl_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [wbkgl_pkg::CFG_BITS-1:0]     csr_wdata
);

   // The controller steps through the request: it accepts a transaction, drops stale
   // stamps from the head of the ring, forms the grant from now and the channel's next
   // allowed time, folds in the burst term, and finally commits the stamp, the channel
   // entry and the result. The commit waits while the result register is still occupied.
   wbkgl_pkg::cmd_type    cmd;
   wbkgl_pkg::status_type status;

   wbkgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the stamp ring and the channel table as memories with registered
   // reads, the configuration registers, and the result register that parts the output side.
   wbkgl_dp #(
      .RING_DEPTH    (RING_DEPTH),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== rtl/core/wbkgl_ctrl.sv =====
// Controller state machine that sequences clearing, pruning, grant computation and commit.
module wbkgl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wbkgl_pkg::status_type status,
   output wbkgl_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRUNE,
      ST_COMPUTE,
      ST_MERGE,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_PRUNE;
            end
         end
         ST_PRUNE: begin
            if (status.prune_hit) begin
               cmd.pop = 1'b1;
            end else begin
               state_in = ST_COMPUTE;
            end
         end
         ST_COMPUTE: begin
            cmd.compute = 1'b1;
            state_in    = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/wbkgl_dp.sv =====
// Datapath with the stamp ring, channel table, configuration registers and result register.
module wbkgl_dp #(
   parameter int RING_DEPTH    = wbkgl_pkg::RING_DEPTH_DEFAULT,
   parameter int CHANNEL_COUNT = wbkgl_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  wbkgl_pkg::req_type                       req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output wbkgl_pkg::rsp_type                       rsp_payload,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [wbkgl_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [wbkgl_pkg::CFG_BITS-1:0]           csr_wdata,
   input  wbkgl_pkg::cmd_type                       cmd,
   output wbkgl_pkg::status_type                    status
);

   localparam int TW    = wbkgl_pkg::TIME_BITS;
   localparam int HW    = $clog2(RING_DEPTH);
   localparam int CW    = $clog2(RING_DEPTH + 1);
   localparam int BW    = (CW > wbkgl_pkg::BURST_BITS) ? CW : wbkgl_pkg::BURST_BITS;
   localparam int CH_AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   localparam logic [HW-1:0]    HEAD_LAST  = HW'(RING_DEPTH - 1);
   localparam logic [CW-1:0]    COUNT_FULL = CW'(RING_DEPTH);
   localparam logic [HW:0]      DEPTH_W    = (HW + 1)'(RING_DEPTH);
   localparam logic [CH_AW-1:0] CLEAR_LAST = CH_AW'(CHANNEL_COUNT - 1);
   localparam logic [12:0]      CH_LIMIT   = 13'(CHANNEL_COUNT);
   localparam logic [TW-1:0]    TIME_MAX   = '1;

   // Configuration registers.
   logic [wbkgl_pkg::CFG_BITS-1:0]   window_ff;
   logic [wbkgl_pkg::BURST_BITS-1:0] burst_ff;
   logic [wbkgl_pkg::CFG_BITS-1:0]   gap_ff;

   // Request registers.
   logic [TW-1:0]                   now_ff;
   logic [wbkgl_pkg::CHAN_BITS-1:0] chan_ff;

   // Ring state and storage.
   logic [HW-1:0] head_ff, head_in, head_next;
   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] ring_mem [RING_DEPTH];
   logic [TW-1:0] ring_rd_ff;
   logic [HW:0]   wr_sum;
   logic [HW-1:0] wr_addr;
   logic          ring_full;

   // Channel table: each entry holds a valid flag above the next allowed time.
   logic [TW:0]      chan_mem [CHANNEL_COUNT];
   logic [TW:0]      chan_rd_ff;
   logic [CH_AW-1:0] chan_addr;
   logic [CH_AW-1:0] clear_ptr_ff;
   logic             chan_ok;
   logic             chan_hit;

   // Grant computation.
   logic [TW:0]   age;
   logic [TW:0]   burst_sum;
   logic [TW-1:0] burst_sat;
   logic [TW:0]   gap_sum;
   logic [TW-1:0] gap_sat;
   logic [TW-1:0] grant_ff;
   logic [TW-1:0] burst_time_ff;
   logic          burst_en_ff;

   logic               rsp_valid_ff;
   wbkgl_pkg::rsp_type rsp_ff;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= wbkgl_pkg::WINDOW_RESET;
         burst_ff  <= wbkgl_pkg::BURST_RESET;
         gap_ff    <= wbkgl_pkg::GAP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            wbkgl_pkg::CSR_WINDOW: window_ff <= csr_wdata;
            wbkgl_pkg::CSR_BURST:  burst_ff  <= csr_wdata[wbkgl_pkg::BURST_BITS-1:0];
            wbkgl_pkg::CSR_GAP:    gap_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         now_ff  <= req_payload.now_time;
         chan_ff <= req_payload.channel_index;
      end
   end

   assign head_next = (head_ff == HEAD_LAST) ? '0 : head_ff + HW'(1);
   assign ring_full = (count_ff == COUNT_FULL);
   assign wr_sum    = {1'b0, head_ff} + (HW + 1)'(count_ff);

   always_comb begin
      if (ring_full) begin
         wr_addr = head_ff;
      end else if (wr_sum >= DEPTH_W) begin
         wr_addr = HW'(wr_sum - DEPTH_W);
      end else begin
         wr_addr = HW'(wr_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.pop) begin
         head_in  = head_next;
         count_in = count_ff - CW'(1);
      end else if (cmd.commit) begin
         if (ring_full) begin
            head_in = head_next;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // The ring is read at the next head, so the read data always matches the head register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ring_mem[wr_addr] <= grant_ff;
      end
      ring_rd_ff <= ring_mem[head_in];
   end

   // A stamp is dropped when now is past it by more than the window.
   assign age = {1'b0, now_ff} - {1'b0, ring_rd_ff};
   assign status.prune_hit = (count_ff != '0) && !age[TW] &&
                             (age[TW-1:0] > TW'(window_ff));

   assign chan_addr = CH_AW'(chan_ff);
   assign chan_ok   = ({7'd0, chan_ff} < CH_LIMIT);
   assign chan_hit  = chan_ok && chan_rd_ff[TW] && (chan_rd_ff[TW-1:0] > now_ff);

   assign burst_sum = {1'b0, ring_rd_ff} + (TW + 1)'(window_ff);
   assign burst_sat = burst_sum[TW] ? TIME_MAX : burst_sum[TW-1:0];
   assign gap_sum   = {1'b0, grant_ff} + (TW + 1)'(gap_ff);
   assign gap_sat   = gap_sum[TW] ? TIME_MAX : gap_sum[TW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         chan_mem[clear_ptr_ff] <= '0;
      end else if (cmd.commit && chan_ok) begin
         chan_mem[chan_addr] <= {1'b1, gap_sat};
      end
      chan_rd_ff <= chan_mem[chan_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff <= '0;
      end else if (cmd.clear && !status.clear_done) begin
         clear_ptr_ff <= clear_ptr_ff + CH_AW'(1);
      end
   end

   assign status.clear_done = (clear_ptr_ff == CLEAR_LAST);

   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         grant_ff      <= chan_hit ? chan_rd_ff[TW-1:0] : now_ff;
         burst_time_ff <= burst_sat;
         burst_en_ff   <= (count_ff != '0) && (BW'(count_ff) >= BW'(burst_ff));
      end else if (cmd.merge) begin
         if (burst_en_ff && (burst_time_ff > grant_ff)) begin
            grant_ff <= burst_time_ff;
         end
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.grant_time  <= grant_ff;
         rsp_ff.was_delayed <= (grant_ff > now_ff);
      end
   end

endmodule

// ===== dv/windowed_burst_and_key_gap_limiter_unit_tb.sv =====
// Self-checking testbench for the windowed burst and per-channel gap send limiter.
module windowed_burst_and_key_gap_limiter_unit_tb;

   localparam int RING_SLOTS = wbkgl_pkg::RING_DEPTH_DEFAULT;
   localparam int CHAN_SLOTS = wbkgl_pkg::CHANNEL_COUNT_DEFAULT;
   localparam int RING_AW    = $clog2(RING_SLOTS);
   localparam int CHAN_AW    = $clog2(CHAN_SLOTS);
   localparam int TB_TIME    = wbkgl_pkg::TIME_BITS;
   localparam int TB_CFG     = wbkgl_pkg::CFG_BITS;
   localparam int TB_CHAN    = wbkgl_pkg::CHAN_BITS;
   localparam int TB_BURST   = wbkgl_pkg::BURST_BITS;
   localparam int TB_IDX     = wbkgl_pkg::CSR_IDX_BITS;

   // The index after the last register. The block must ignore writes to it.
   localparam logic [TB_IDX-1:0] CSR_UNMAPPED = 2'd3;

   // Results that have not come back yet stay in the queue while the receiver holds off.
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_SPACING = 550;

   // Before a result leaves the block, pruning drops at most the ring depth in stamps.
   localparam int SETTLE_CYCLES = RING_SLOTS + 16;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   wbkgl_pkg::req_type            req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   wbkgl_pkg::rsp_type            rsp_payload;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [TB_IDX-1:0]             csr_index = '0;
   logic [TB_CFG-1:0]             csr_wdata = '0;

   windowed_burst_and_key_gap_limiter_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Predicted copy of the limiter's registers and state. The stamp log keeps the send
   // stamps oldest first, starting at log_head, with log_count live entries.
   logic [TB_CFG-1:0]   window_cfg = wbkgl_pkg::WINDOW_RESET;
   logic [TB_BURST-1:0] burst_cfg  = wbkgl_pkg::BURST_RESET;
   logic [TB_CFG-1:0]   gap_cfg    = wbkgl_pkg::GAP_RESET;
   logic [TB_TIME-1:0]  stamp_log [RING_SLOTS];
   int                  log_head = 0;
   int                  log_count = 0;
   logic [TB_TIME-1:0]  chan_next [CHAN_SLOTS];
   bit                  chan_armed [CHAN_SLOTS];

   wbkgl_pkg::req_type send_req_q [$];     // requests waiting to be offered to the block
   wbkgl_pkg::rsp_type grant_expect_q [$]; // predicted grants, oldest first

   int reqs_offered = 0;
   int reqs_taken = 0;
   int grants_checked = 0;
   int delayed_total = 0;
   int overwrite_total = 0;
   int csr_writes = 0;
   int fault_count = 0;
   int idle_pct = 8;
   int hold_left = 0;
   int next_hold_at = 150;
   logic [TB_TIME-1:0] cur_time = '0;
   wbkgl_pkg::rsp_type want;

   initial begin
      foreach (chan_armed[i]) chan_armed[i] = 1'b0;
   end

   // Adds a register value to a time and clamps at the largest time instead of wrapping.
   function automatic logic [TB_TIME-1:0] sat_time(input logic [TB_TIME-1:0] base,
                                                   input logic [TB_CFG-1:0] extra);
      logic [TB_TIME:0] total;
      total = {1'b0, base} + {{(TB_TIME + 1 - TB_CFG){1'b0}}, extra};
      return total[TB_TIME] ? {TB_TIME{1'b1}} : total[TB_TIME-1:0];
   endfunction

   // Works out the grant for one send request and moves the predicted state on.
   function automatic wbkgl_pkg::rsp_type next_grant(input wbkgl_pkg::req_type rq);
      logic [TB_TIME-1:0] now_t;
      logic [TB_TIME-1:0] grant;
      logic [TB_TIME-1:0] oldest;
      logic [TB_TIME-1:0] burst_edge;
      bit                 pruning;
      int                 ch;
      wbkgl_pkg::rsp_type res;
      now_t = rq.now_time;
      grant = now_t;
      ch = int'(rq.channel_index);

      // Stamps that have aged out of the window are dropped from the old end. A stamp that
      // lies ahead of the current time has a negative age and stops the pruning.
      pruning = 1'b1;
      while (pruning && log_count != 0) begin
         oldest = stamp_log[RING_AW'(log_head)];
         if (now_t > oldest && (now_t - oldest) > TB_TIME'(window_cfg)) begin
            log_head = (log_head + 1) % RING_SLOTS;
            log_count--;
         end else begin
            pruning = 1'b0;
         end
      end

      if (ch < CHAN_SLOTS && chan_armed[CHAN_AW'(ch)] && chan_next[CHAN_AW'(ch)] > grant) begin
         grant = chan_next[CHAN_AW'(ch)];
      end

      // Once the window holds the burst allowance, the send waits until the oldest stamp
      // leaves the window. A zero allowance means any live stamp is enough; an allowance
      // above the ring depth is never reached.
      if (log_count != 0 && log_count >= int'(burst_cfg)) begin
         burst_edge = sat_time(stamp_log[RING_AW'(log_head)], window_cfg);
         if (burst_edge > grant) grant = burst_edge;
      end

      // A full ring loses its oldest stamp to the new one.
      if (log_count < RING_SLOTS) begin
         stamp_log[RING_AW'((log_head + log_count) % RING_SLOTS)] = grant;
         log_count++;
      end else begin
         stamp_log[RING_AW'(log_head)] = grant;
         log_head = (log_head + 1) % RING_SLOTS;
         overwrite_total++;
      end

      if (ch < CHAN_SLOTS) begin
         chan_next[CHAN_AW'(ch)] = sat_time(grant, gap_cfg);
         chan_armed[CHAN_AW'(ch)] = 1'b1;
      end

      res.grant_time = grant;
      res.was_delayed = (grant > now_t);
      if (res.was_delayed) delayed_total++;
      return res;
   endfunction

   // Request driver. The prediction is made at the edge where the block takes a request,
   // so that it always sees the registers that the block holds at that moment. A new
   // request is put up only when the current one is gone or was never there.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            grant_expect_q = {grant_expect_q, next_grant(req_payload)};
            reqs_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= send_req_q[0];
               send_req_q.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every transaction on the result channel is matched against the oldest
   // prediction. The monitor also paces rsp_ready: random idling, and now and then a long
   // hold-off during which the block fills up and must stop taking requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grant_expect_q.size() == 0) begin
               $error("result transaction with nothing expected: grant_time %0h was_delayed %0b",
                      rsp_payload.grant_time, rsp_payload.was_delayed);
               fault_count++;
            end else begin
               want = grant_expect_q[0];
               grant_expect_q.delete(0);
               if (rsp_payload.grant_time !== want.grant_time) begin
                  $error("grant_time: expected %0h, got %0h", want.grant_time,
                         rsp_payload.grant_time);
                  fault_count++;
               end
               if (rsp_payload.was_delayed !== want.was_delayed) begin
                  $error("was_delayed: expected %0b, got %0b", want.was_delayed,
                         rsp_payload.was_delayed);
                  fault_count++;
               end
            end
            grants_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (grants_checked >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += HOLD_SPACING;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // Register write on the configuration channel. The predicted copy changes only once the
   // block has taken the transaction; an index past the register list changes nothing.
   task automatic write_csr(input logic [TB_IDX-1:0] idx, input logic [TB_CFG-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         wbkgl_pkg::CSR_WINDOW: window_cfg = data;
         wbkgl_pkg::CSR_BURST:  burst_cfg = data[TB_BURST-1:0];
         wbkgl_pkg::CSR_GAP:    gap_cfg = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic queue_req(input logic [TB_TIME-1:0] t, input logic [TB_CHAN-1:0] ch);
      wbkgl_pkg::req_type rq;
      rq.now_time = t;
      rq.channel_index = ch;
      send_req_q = {send_req_q, rq};
      reqs_offered++;
   endtask

   // Random traffic. Most requests move time forward by a small step, as real sends do.
   // A few leap far ahead and empty the window, and a few carry a time from the recent
   // past, so that stamps and channel times lie ahead of the request. Most traffic goes
   // to a handful of busy channels so the per-channel gap keeps biting.
   task automatic queue_phase(input int n, input int unsigned max_step);
      logic [TB_TIME:0]   ahead;
      logic [TB_TIME-1:0] back;
      logic [TB_TIME-1:0] t;
      logic [TB_CHAN-1:0] ch;
      int                 roll;
      int                 i;
      for (i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 5) ahead = {1'b0, cur_time} + (TB_TIME + 1)'($urandom);
         else ahead = {1'b0, cur_time} + (TB_TIME + 1)'($urandom_range(max_step));
         cur_time = ahead[TB_TIME] ? {TB_TIME{1'b1}} : ahead[TB_TIME-1:0];
         t = cur_time;
         if (roll >= 5 && roll < 14) begin
            back = TB_TIME'($urandom_range(4 * max_step + 1));
            t = (back > cur_time) ? '0 : cur_time - back;
         end
         if ($urandom_range(3) == 0) ch = TB_CHAN'($urandom);
         else ch = TB_CHAN'($urandom_range(7));
         queue_req(t, ch);
      end
   endtask

   // Waits until every request has been taken and answered, then lets the block go quiet.
   task automatic settle();
      while (reqs_taken != reqs_offered || grant_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: a tight window with a burst allowance of three. The first sends run into
      // the channel gap and then the burst limit, a late send prunes the old stamps, and a
      // send from the past sees stamps ahead of it that must not be pruned.
      write_csr(wbkgl_pkg::CSR_WINDOW, 32'd100);
      write_csr(wbkgl_pkg::CSR_BURST, 32'd3);
      write_csr(wbkgl_pkg::CSR_GAP, 32'd10);
      queue_req(48'd0, 6'd0);
      queue_req(48'd0, 6'd0);
      queue_req(48'd5, 6'd1);
      queue_req(48'd5, 6'd2);
      queue_req(48'd50, 6'd3);
      queue_req(48'd150, 6'd0);
      queue_req(48'd20, 6'd4);
      queue_req(48'd1000, 6'd63);
      settle();

      // Directed: a zero burst allowance, so any live stamp holds the next send back.
      write_csr(wbkgl_pkg::CSR_BURST, 32'd0);
      write_csr(wbkgl_pkg::CSR_GAP, 32'd0);
      queue_req(48'd1000, 6'd5);
      queue_req(48'd1000, 6'd5);
      queue_req(48'd1001, 6'd6);
      queue_req(48'd1300, 6'd7);
      settle();

      // Directed: a one-tick window and the widest gap. The write to the unmapped index must
      // leave the window at one tick.
      write_csr(wbkgl_pkg::CSR_WINDOW, 32'd1);
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      write_csr(wbkgl_pkg::CSR_GAP, 32'hFFFF_FFFF);
      write_csr(wbkgl_pkg::CSR_BURST, 32'd1);
      queue_req(48'd2000, 6'd8);
      queue_req(48'd2001, 6'd9);
      queue_req(48'd2001, 6'd9);
      queue_req(48'd2003, 6'd10);
      queue_req(48'd2003, 6'd63);
      queue_req(48'd2004, 6'd0);
      settle();

      // Random: the reset settings, starting from a random point high in the time range.
      // The receiver's first long hold-off falls in this phase.
      cur_time = {1'b0, 15'($urandom | 1), 32'($urandom)};
      write_csr(wbkgl_pkg::CSR_WINDOW, wbkgl_pkg::WINDOW_RESET);
      write_csr(wbkgl_pkg::CSR_BURST, TB_CFG'(wbkgl_pkg::BURST_RESET));
      write_csr(wbkgl_pkg::CSR_GAP, wbkgl_pkg::GAP_RESET);
      queue_phase(290, 3000);
      settle();

      // Random: a one-tick window and an allowance of one with no gap, at full rate on both sides.
      idle_pct = 0;
      write_csr(wbkgl_pkg::CSR_WINDOW, 32'd1);
      write_csr(wbkgl_pkg::CSR_BURST, 32'd1);
      write_csr(wbkgl_pkg::CSR_GAP, 32'd0);
      queue_phase(290, 3);
      settle();

      // Random: an allowance equal to the ring depth with dense traffic fills the ring.
      idle_pct = 8;
      write_csr(wbkgl_pkg::CSR_WINDOW, 32'd500);
      write_csr(wbkgl_pkg::CSR_BURST, 32'd32);
      write_csr(wbkgl_pkg::CSR_GAP, 32'd50);
      queue_phase(290, 40);
      settle();

      // Random: the widest window and an allowance past the ring depth. The burst term never
      // applies, and the ring keeps overwriting its oldest stamp.
      write_csr(wbkgl_pkg::CSR_WINDOW, 32'hFFFF_FFFF);
      write_csr(wbkgl_pkg::CSR_BURST, 32'd63);
      write_csr(wbkgl_pkg::CSR_GAP, 32'd7);
      queue_phase(290, 10);
      settle();

      // Random: a zero allowance against a gap longer than the window.
      write_csr(wbkgl_pkg::CSR_WINDOW, 32'd200);
      write_csr(wbkgl_pkg::CSR_BURST, 32'd0);
      write_csr(wbkgl_pkg::CSR_GAP, 32'd300);
      queue_phase(290, 100);
      settle();

      // Random: times near the top of the range, where both the window sum and the gap sum
      // clamp at the largest time.
      cur_time = {TB_TIME{1'b1}} - TB_TIME'($urandom_range(1 << 24));
      write_csr(wbkgl_pkg::CSR_WINDOW, 32'hFFFF_FFFF);
      write_csr(wbkgl_pkg::CSR_BURST, 32'd5);
      write_csr(wbkgl_pkg::CSR_GAP, 32'hFFFF_FFFF);
      queue_phase(290, 5000);
      settle();

      $display("Ran %0d send requests under %0d register writes; %0d grants checked, %0d delayed.",
               reqs_taken, csr_writes, grants_checked, delayed_total);
      $display("The stamp ring overwrote its oldest stamp %0d times.", overwrite_total);
      if (fault_count == 0) begin
         $display("windowed_burst_and_key_gap_limiter_unit_tb: PASS");
      end else begin
         $display("windowed_burst_and_key_gap_limiter_unit_tb: FAIL");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run of this stimulus.
   initial begin
      #2_000_000;
      $display("windowed_burst_and_key_gap_limiter_unit_tb: FAIL");
      $finish;
   end

endmodule
